[rtl/plc_pkg.sv]
// package for the positional list store: command codes, field widths,
// default capacity and the command broadcast that runs along the cell row
// no dependencies
package plc_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 5;
    localparam int CNT_OUT_W    = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } plc_cmd_t;

    // command as seen by every cell in the row
    typedef struct packed {
        logic             ins_ok;
        logic             rem_ok;
        logic [POS_W-1:0] pidx;
    } plc_bcast_t;

endpackage

[rtl/plc_cell.sv]
// one cell of the list row: holds the entry at a fixed index and moves it
// to or from its neighbors on insert and remove
// depends on plc_pkg
module plc_cell #(
    parameter int INDEX = 0
) (
    input  logic                      clk,
    input  plc_pkg::plc_bcast_t       bcast,
    input  logic [plc_pkg::DATA_W-1:0] item,
    input  logic [plc_pkg::DATA_W-1:0] left_data,
    input  logic [plc_pkg::DATA_W-1:0] right_data,
    output logic [plc_pkg::DATA_W-1:0] data,
    output logic [plc_pkg::DATA_W-1:0] rd_data
);
    import plc_pkg::*;

    localparam logic [31:0] IDX = 32'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [31:0]       pidx_ext;
    logic              hit;
    logic              above;

    // where this cell sits relative to the target position
    assign pidx_ext = 32'(bcast.pidx);
    assign hit      = (IDX == pidx_ext);
    assign above    = (IDX > pidx_ext);

    // next entry: new item, left neighbor or right neighbor
    always_comb
    begin
        data_next = data_reg;
        if (bcast.ins_ok && hit)
        begin
            data_next = item;
        end
        else if (bcast.ins_ok && above)
        begin
            data_next = left_data;
        end
        else if (bcast.rem_ok && (hit || above))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // drive the read bus only when addressed
    assign rd_data = hit ? data_reg : '0;

endmodule

[rtl/positional_list_store.sv]
// top level of the positional list store: command decode, fill count,
// result register and the row of plc_cell entries
// depends on plc_pkg and plc_cell
//
// usage:
//   a command beat is taken at a rising edge where start is high and busy is
//   low; busy is always low, so one command can be issued every cycle.
//   cmd selects insert, remove, read or clear; position is 1-based.
//   each command gives exactly one result beat, in the cycle after it is taken:
//   done is high for that single cycle with ok, item_out, count, is_empty and
//   is_full valid. throughput is one command per cycle, as the cell row
//   shifts all entries in the same register update.
//   insert shifts entries at and above the position up one cell, remove
//   shifts them down one cell; both are refused (ok low, state kept) on an
//   invalid position, and insert also when the list is full.
//   refused commands, insert and clear report item_out as zero.
//   the receiver has no way to stall; a result beat is gone after its cycle.
//   reset clears the fill count and the result strobe; entry contents are
//   not cleared and only positions 1..count are ever read back.
module positional_list_store #(
    parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  plc_pkg::plc_cmd_t             cmd,
    input  logic [plc_pkg::POS_W-1:0]     position,
    input  logic signed [plc_pkg::DATA_W-1:0] item_in,
    output logic                          done,
    output logic                          ok,
    output logic signed [plc_pkg::DATA_W-1:0] item_out,
    output logic [plc_pkg::CNT_OUT_W-1:0] count,
    output logic                          is_empty,
    output logic                          is_full
);
    import plc_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              done_reg;
    logic              ok_reg;
    logic              ok_next;
    logic [DATA_W-1:0] item_out_reg;
    logic [DATA_W-1:0] item_out_next;

    logic              accept;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              pos_in_list;
    logic              pos_ins_ok;
    plc_bcast_t        bcast;
    logic [DATA_W-1:0] rd_bus;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_rd   [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // position checks against the current fill count
    assign pos_ext     = CMP_W'(position);
    assign cnt_ext     = CMP_W'(count_reg);
    assign pos_in_list = (position != '0) && (pos_ext <= cnt_ext);
    assign pos_ins_ok  = (position != '0) && (pos_ext <= cnt_ext + CMP_W'(1))
                         && (cnt_ext < CAP_C);

    // command broadcast to the cell row
    always_comb
    begin
        bcast.ins_ok = accept && (cmd == CMD_INSERT) && pos_ins_ok;
        bcast.rem_ok = accept && (cmd == CMD_REMOVE) && pos_in_list;
        bcast.pidx   = position - POS_W'(1);
    end

    // row of entry cells, each wired to its neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = item_in;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        plc_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .bcast      (bcast),
            .item       (item_in),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // read bus: only the addressed cell drives nonzero
    always_comb
    begin
        rd_bus = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            rd_bus = rd_bus | cell_rd[k];
        end
    end

    // command decode: next count and result beat
    always_comb
    begin
        count_next    = count_reg;
        ok_next       = 1'b0;
        item_out_next = '0;
        case (cmd)
            CMD_INSERT:
            begin
                if (pos_ins_ok)
                begin
                    ok_next    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (pos_in_list)
                begin
                    ok_next       = 1'b1;
                    item_out_next = rd_bus;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            CMD_READ:
            begin
                if (pos_in_list)
                begin
                    ok_next       = 1'b1;
                    item_out_next = rd_bus;
                end
            end
            CMD_CLEAR:
            begin
                ok_next    = 1'b1;
                count_next = '0;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg       <= ok_next;
            item_out_reg <= item_out_next;
        end
    end

    assign done     = done_reg;
    assign ok       = ok_reg;
    assign item_out = item_out_reg;
    assign count    = CNT_OUT_W'(count_reg);
    assign is_empty = (count_reg == '0);
    assign is_full  = (cnt_ext == CAP_C);

endmodule
